/* design/image_block_pooling_top_macros.svh */
// ----------------------------------------------------------------------------
// image_block_pooling_top_macros.svh
// Assertion macros used by the checker file ibp_checker.
// ----------------------------------------------------------------------------
`ifndef IMAGE_BLOCK_POOLING_TOP_MACROS_SVH
`define IMAGE_BLOCK_POOLING_TOP_MACROS_SVH

// same-cycle implication
`define IBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibp assertion failed");

// next-cycle implication
`define IBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibp assertion failed");

`endif

/* design/ibp_pkg.sv */
// ----------------------------------------------------------------------------
// ibp_pkg
// Shared constants and types of the block pooling design.
// ----------------------------------------------------------------------------
package ibp_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int MAX_BLOCK_DEF    = 16;

    localparam int DIV_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int TDATA_OUT_W = 40;

    localparam logic [IDX_W-1:0] REG_POOL_MODE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd1;
    localparam logic [IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd5;

    localparam logic MODE_AVG = 1'b0;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

endpackage

/* design/ibp_ram.sv */
// ----------------------------------------------------------------------------
// ibp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/ibp_div.sv */
// ----------------------------------------------------------------------------
// ibp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ibp_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ibp_pkg::div_req_t       req,
    output logic                    done,
    output logic [ibp_pkg::DIV_W-1:0] quot
);

    localparam int W  = ibp_pkg::DIV_W;
    localparam int NW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [NW-1:0] cnt_reg;
    logic [W:0]    rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dvs_reg;
    logic [W:0]    trial;
    logic          fits;

    assign trial = {rem_reg[W-1:0], quo_reg[W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == NW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, dvs_reg}) : trial;
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

/* design/image_block_pooling_top.sv */
// ----------------------------------------------------------------------------
// image_block_pooling_top
// Average / max pooling of an interleaved 8-bit raster image over
// non-overlapping blocks, one partial value per column block and channel.
// ----------------------------------------------------------------------------
//
//  channel  | dir | signals                         | content
//  ---------+-----+---------------------------------+-------------------------
//  s_axis   | in  | s_tvalid s_tready s_tdata[7:0]  | one sample
//  m_axis   | out | m_tvalid m_tready m_tdata m_tlast | pooled result, last=image end
//  config   | in  | cfg_we cfg_index cfg_data       | register writes
//
//  Steps: an item that closes no block passes through the column divide,
//  result handoff, RAM read and write-back. A closing item adds the
//  block-row divide and the output load and, in average mode, the mean
//  divide; all three divides share one bit-serial divider.
//  Reset clears counters and control; the partial store is not cleared.
//  A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module image_block_pooling_top #(
    parameter int MAX_WIDTH    = ibp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = ibp_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_BLOCK    = ibp_pkg::MAX_BLOCK_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // sample[7:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // block_col[9:0] block_row[25:10] chan[27:26] pooled[35:28] zero[39:36]
    output logic [ibp_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic                          m_tlast,   // image_done
    input  logic                          cfg_we,
    input  logic [ibp_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ibp_pkg::CFG_W-1:0]     cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);             // pixel column
    localparam int BKW   = (MAX_BLOCK > 2) ? $clog2(MAX_BLOCK) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = ibp_pkg::DIV_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DCOL = 7'b0000010,
        S_RD   = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_DROW = 7'b0010000,
        S_DAVG = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic        mode_reg;
    logic [4:0]  bw_reg, bh_reg;
    logic [10:0] iw_reg;
    logic [15:0] ih_reg;
    logic [2:0]  cc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            bw_reg   <= 5'd2;
            bh_reg   <= 5'd2;
            iw_reg   <= 11'd640;
            ih_reg   <= 16'd480;
            cc_reg   <= 3'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ibp_pkg::REG_POOL_MODE:     mode_reg <= cfg_data[0];
                ibp_pkg::REG_BLOCK_WIDTH:   bw_reg   <= cfg_data[4:0];
                ibp_pkg::REG_BLOCK_HEIGHT:  bh_reg   <= cfg_data[4:0];
                ibp_pkg::REG_IMAGE_WIDTH:   iw_reg   <= cfg_data[10:0];
                ibp_pkg::REG_IMAGE_HEIGHT:  ih_reg   <= cfg_data[15:0];
                ibp_pkg::REG_CHANNEL_COUNT: cc_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamped register values, all compared at 17 bits
    logic [16:0] bw_c, bh_c, iw_c, ih_c, cc_c;

    always_comb
    begin
        bw_c = (bw_reg == 5'd0) ? 17'd1 :
               (17'(bw_reg) > 17'(MAX_BLOCK)) ? 17'(MAX_BLOCK) : 17'(bw_reg);
        bh_c = (bh_reg == 5'd0) ? 17'd1 :
               (17'(bh_reg) > 17'(MAX_BLOCK)) ? 17'(MAX_BLOCK) : 17'(bh_reg);
        iw_c = (iw_reg == 11'd0) ? 17'd1 :
               (17'(iw_reg) > 17'(MAX_WIDTH)) ? 17'(MAX_WIDTH) : 17'(iw_reg);
        ih_c = (ih_reg == 16'd0) ? 17'd1 : 17'(ih_reg);
        cc_c = (cc_reg == 3'd0) ? 17'd1 :
               (17'(cc_reg) > 17'(MAX_CHANNELS)) ? 17'(MAX_CHANNELS) : 17'(cc_reg);
    end

    // position counters
    logic [CW-1:0]  pcol_reg;
    logic [15:0]    prow_reg;
    logic [1:0]     chan_reg;
    logic [BKW-1:0] cib_reg, rib_reg;

    logic col_end, row_end, last_col, last_row, last_chan, first, emit;
    logic [1:0] ch;

    always_comb
    begin
        last_col  = 17'(pcol_reg) + 17'd1 >= iw_c;
        last_row  = 17'(prow_reg) + 17'd1 >= ih_c;
        last_chan = 17'(chan_reg) + 17'd1 >= cc_c;
        col_end   = (17'(cib_reg) + 17'd1 >= bw_c) || last_col;
        row_end   = (17'(rib_reg) + 17'd1 >= bh_c) || last_row;
        first     = (cib_reg == '0) && (rib_reg == '0);
        emit      = col_end && row_end;
        ch        = (int'(chan_reg) >= MAX_CHANNELS) ? chan_reg - 2'(MAX_CHANNELS) : chan_reg;
    end

    // item datapath registers
    logic [7:0]    sample_reg;
    logic [CW-1:0] bcol_reg;
    logic [15:0]   brow_reg;
    logic [15:0]   acc_reg;
    logic [15:0]   cnt_reg;
    logic [1:0]    ech_reg;
    logic          edone_reg;
    logic [7:0]    val_reg;

    // partial store
    logic [AW-1:0] addr;
    logic [15:0]   rdata;
    logic          we;
    logic [15:0]   acc;
    logic [16:0]   sum;

    assign addr = AW'(int'(bcol_reg) * MAX_CHANNELS + int'(ch));
    assign we   = state_reg == S_MOD;

    always_comb
    begin
        sum = 17'(rdata) + 17'(sample_reg);
        if (first)
            acc = 16'(sample_reg);
        else if (mode_reg == ibp_pkg::MODE_AVG)
            acc = sum[16] ? 16'hFFFF : sum[15:0];
        else
            acc = (16'(sample_reg) > rdata) ? 16'(sample_reg) : rdata;
    end

    ibp_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (addr),
        .wdata (acc),
        .raddr (addr),
        .rdata (rdata)
    );

    // shared divider
    ibp_pkg::div_req_t div_req;
    logic              div_done;
    logic [DW-1:0]     div_q;

    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_IDLE:
            begin
                div_req.start    = s_tvalid;
                div_req.dividend = DW'(pcol_reg);
                div_req.divisor  = DW'(bw_c);
            end
            S_MOD:
            begin
                div_req.start    = emit;
                div_req.dividend = prow_reg;
                div_req.divisor  = DW'(bh_c);
            end
            S_DROW:
            begin
                div_req.start    = div_done && (mode_reg == ibp_pkg::MODE_AVG);
                div_req.dividend = acc_reg;
                div_req.divisor  = cnt_reg;
            end
            default: ;
        endcase
    end

    ibp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    function automatic logic [7:0] sat8(input logic [15:0] v);
        sat8 = (v > 16'd255) ? 8'hFF : v[7:0];
    endfunction

    // output register
    logic        out_free;
    logic        mvalid_reg;
    logic [39:0] mdata_reg;
    logic        mlast_reg;

    assign out_free = !mvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_DCOL;
            S_DCOL: if (div_done) state_next = S_RD;
            S_RD:   state_next = S_MOD;
            S_MOD:  state_next = emit ? S_DROW : S_IDLE;
            S_DROW:
                if (div_done)
                    state_next = (mode_reg == ibp_pkg::MODE_AVG) ? S_DAVG : S_OUT;
            S_DAVG: if (div_done) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pcol_reg   <= '0;
            prow_reg   <= '0;
            chan_reg   <= '0;
            cib_reg    <= '0;
            rib_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_MOD)
            begin
                if (!last_chan)
                    chan_reg <= chan_reg + 2'd1;
                else
                begin
                    chan_reg <= '0;
                    if (!last_col)
                    begin
                        pcol_reg <= pcol_reg + 1'b1;
                        cib_reg  <= col_end ? '0 : cib_reg + 1'b1;
                    end
                    else
                    begin
                        pcol_reg <= '0;
                        cib_reg  <= '0;
                        if (!last_row)
                        begin
                            prow_reg <= prow_reg + 16'd1;
                            rib_reg  <= row_end ? '0 : rib_reg + 1'b1;
                        end
                        else
                        begin
                            prow_reg <= '0;
                            rib_reg  <= '0;
                        end
                    end
                end
            end
            if (state_reg == S_OUT && out_free)
                mvalid_reg <= 1'b1;
            else if (m_tready)
                mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
            sample_reg <= s_tdata;
        if (state_reg == S_DCOL && div_done)
            bcol_reg <= CW'(div_q);
        if (state_reg == S_MOD)
        begin
            acc_reg   <= acc;
            cnt_reg   <= 16'((32'(cib_reg) + 32'd1) * (32'(rib_reg) + 32'd1));
            ech_reg   <= ch;
            edone_reg <= last_col && last_row && last_chan;
        end
        if (state_reg == S_DROW && div_done)
        begin
            brow_reg <= div_q;
            val_reg  <= sat8(acc_reg);
        end
        if (state_reg == S_DAVG && div_done)
            val_reg <= sat8(div_q);
        if (state_reg == S_OUT && out_free)
        begin
            mdata_reg <= {4'd0, val_reg, ech_reg, brow_reg, 10'(bcol_reg)};
            mlast_reg <= edone_reg;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

endmodule

/* design/ibp_checker.sv */
// ----------------------------------------------------------------------------
// ibp_checker
// Port-level checks of the block pooling top level, bound to it.
// ----------------------------------------------------------------------------
`include "image_block_pooling_top_macros.svh"

module ibp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ibp_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic                          m_tlast
);

    `IBP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `IBP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `IBP_ASSERT_NOW(a_no_fast_result, clk, rst_n, $rose(m_tvalid), !$past(s_tvalid && s_tready))

endmodule

bind image_block_pooling_top ibp_checker u_ibp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
